// ===== rtl/grst_pkg.sv =====
package grst_pkg;

  localparam int SIDE       = 256;
  localparam int VALUE_BITS = 16;
  localparam int COORD_W    = 8;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = 32;

  localparam int TREE_H = 1 << $clog2(SIDE);
  localparam int NB     = $clog2(TREE_H) + 1;
  localparam int CB     = NB + 1;
  localparam int AW     = 2 * NB;
  localparam int DEPTH  = 1 << AW;

  localparam logic [SUM_W-1:0] VMASK = (VALUE_BITS >= SUM_W) ? {SUM_W{1'b1}} :
                                       SUM_W'((64'(1) << VALUE_BITS) - 64'(1));

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LEAF,
    ST_CCHK,
    ST_SA,
    ST_SB,
    ST_SW,
    ST_QROW,
    ST_QROWH,
    ST_QSHIFT,
    ST_CLO,
    ST_CLOD,
    ST_CHI,
    ST_CHID,
    ST_QOUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic leaf_wr;
    logic jc_shift;
    logic i_shift;
    logic row_mode;
    logic rd_a;
    logic rd_b;
    logic lat_a;
    logic sum_wr;
    logic row_lo_take;
    logic row_hi_take;
    logic row_shift;
    logic col_lo_rd;
    logic col_hi_rd;
    logic acc;
    logic col_shift;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic upd_ok;
    logic jc_gt1;
    logic i_gt1;
    logic rlo_lt;
    logic rlo_odd;
    logic rhi_odd;
    logic clo_lt;
    logic clo_odd;
    logic chi_odd;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/grid_rectangle_sum_tree_core.sv =====
// Two-dimensional segment tree of 32-bit partial sums over a 256 x 256 grid.
// Input channel in_*: in_tuser is func (0 = set one cell, 1 = rectangle query),
// in_tdata carries the cell coordinates, the second query corner and the value.
// Output channel out_*: one rect_sum transaction per query; updates give none.
// Updates outside the grid are dropped; query corners saturate at the last
// row or column and are swapped when given in reverse order.
// Update: the leaf is written in ST_LEAF, then 80 sums are rebuilt, each through
// the states ST_CCHK, ST_SA, ST_SB and ST_SW on the tree memory. A query
// visits up to 2*log2 256 row nodes; each walks up to 9 column levels through
// ST_CLO and ST_CHI, with ST_CLOD or ST_CHID for each column read, and each row
// level passes ST_QROW, ST_QROWH and ST_QSHIFT. One item is processed at a
// time.
// The result sits in an output register; the next item is accepted while it
// waits, and a later query holds in its final state until the register frees.
// Reset: a clearing pass writes zero to all 262144 tree words, one per cycle,
// during which in_tready stays low.
module grid_rectangle_sum_tree_core import grst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // col_a, row_a, col_b, row_b, value
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SUM_W-1:0]      out_tdata   // rect_sum
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  grst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  grst_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .col_a        (in_tdata[7:0]),
    .row_a        (in_tdata[15:8]),
    .col_b        (in_tdata[23:16]),
    .row_b        (in_tdata[31:24]),
    .value        (in_tdata[47:32]),
    .out_tready   (out_tready),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_rect_sum (out_tdata)
  );

`ifndef SYNTH
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> cmd.load)
    else $error("accepted transaction not loaded");

  a_load_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.clr_wr || cmd.leaf_wr || cmd.sum_wr))
    else $error("tree write during load");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !cmd.out_load)
    else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/grst_ctrl.sv =====
module grst_ctrl import grst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_func,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   mode_r, mode_nxt;
  logic   ret_hi_r, ret_hi_nxt;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    ret_hi_nxt = ret_hi_r;
    unique case (state_r)
      ST_CLR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = (in_func == FUNC_QUERY) ? ST_QROW : ST_LEAF;
      end
      ST_LEAF: begin
        state_nxt = sts.upd_ok ? ST_CCHK : ST_IDLE;
      end
      ST_CCHK: begin
        if (sts.jc_gt1) begin
          mode_nxt  = 1'b0;
          state_nxt = ST_SA;
        end else if (sts.i_gt1) begin
          mode_nxt  = 1'b1;
          state_nxt = ST_SA;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SA: state_nxt = ST_SB;
      ST_SB: state_nxt = ST_SW;
      ST_SW: state_nxt = ST_CCHK;
      ST_QROW: begin
        if (!sts.rlo_lt) begin
          state_nxt = ST_QOUT;
        end else if (sts.rlo_odd) begin
          ret_hi_nxt = 1'b0;
          state_nxt  = ST_CLO;
        end else begin
          state_nxt = ST_QROWH;
        end
      end
      ST_QROWH: begin
        if (sts.rhi_odd) begin
          ret_hi_nxt = 1'b1;
          state_nxt  = ST_CLO;
        end else begin
          state_nxt = ST_QSHIFT;
        end
      end
      ST_QSHIFT: state_nxt = ST_QROW;
      ST_CLO: begin
        if (!sts.clo_lt) state_nxt = ret_hi_r ? ST_QSHIFT : ST_QROWH;
        else if (sts.clo_odd) state_nxt = ST_CLOD;
        else state_nxt = ST_CHI;
      end
      ST_CLOD: state_nxt = ST_CHI;
      ST_CHI: state_nxt = sts.chi_odd ? ST_CHID : ST_CLO;
      ST_CHID: state_nxt = ST_CLO;
      ST_QOUT: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    cmd.row_mode = mode_r;
    unique case (state_r)
      ST_CLR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_LEAF: cmd.leaf_wr = sts.upd_ok;
      ST_CCHK: begin
        cmd.jc_shift = sts.jc_gt1;
        cmd.i_shift  = !sts.jc_gt1 && sts.i_gt1;
      end
      ST_SA: cmd.rd_a = 1'b1;
      ST_SB: begin
        cmd.rd_b  = 1'b1;
        cmd.lat_a = 1'b1;
      end
      ST_SW: cmd.sum_wr = 1'b1;
      ST_QROW: cmd.row_lo_take = sts.rlo_lt && sts.rlo_odd;
      ST_QROWH: cmd.row_hi_take = sts.rhi_odd;
      ST_QSHIFT: cmd.row_shift = 1'b1;
      ST_CLO: cmd.col_lo_rd = sts.clo_lt && sts.clo_odd;
      ST_CLOD: cmd.acc = 1'b1;
      ST_CHI: begin
        cmd.col_hi_rd = sts.chi_odd;
        cmd.col_shift = !sts.chi_odd;
      end
      ST_CHID: begin
        cmd.acc       = 1'b1;
        cmd.col_shift = 1'b1;
      end
      ST_QOUT: cmd.out_load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      mode_r   <= 1'b0;
      ret_hi_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      ret_hi_r <= ret_hi_nxt;
    end
  end

endmodule

// ===== rtl/grst_dpath.sv =====
module grst_dpath import grst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [COORD_W-1:0] col_a,
  input  logic [COORD_W-1:0] row_a,
  input  logic [COORD_W-1:0] col_b,
  input  logic [COORD_W-1:0] row_b,
  input  logic [VAL_W-1:0]   value,
  input  logic               out_tready,
  output dp_sts_t            sts,
  output logic               out_tvalid,
  output logic [SUM_W-1:0]   out_rect_sum
);

  function automatic logic [CB-1:0] clamp(input logic [COORD_W-1:0] c);
    return (32'(c) >= 32'(SIDE)) ? CB'(SIDE - 1) : CB'(c);
  endfunction

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata_r;

  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_data_r, out_data_nxt;
  logic             ok_r, ok_nxt;
  logic [NB-1:0]    i_r, i_nxt, j_r, j_nxt, jc_r, jc_nxt, cur_r, cur_nxt;
  logic [SUM_W-1:0] v_r, v_nxt, tmp_r, tmp_nxt, tot_r, tot_nxt;
  logic [CB-1:0]    cbl_r, cbl_nxt, cbh_r, cbh_nxt;
  logic [CB-1:0]    rlo_r, rlo_nxt, rhi_r, rhi_nxt, clo_r, clo_nxt, chi_r, chi_nxt;

  logic [CB-1:0]    c0, c1, r0, r1, cmin, cmax, rmin, rmax, rhi_m1, chi_m1;
  logic [NB-1:0]    i2, j2;
  logic             we;
  logic [AW-1:0]    wa, ra;
  logic [SUM_W-1:0] wd;

  assign c0     = clamp(col_a);
  assign c1     = clamp(col_b);
  assign r0     = clamp(row_a);
  assign r1     = clamp(row_b);
  assign cmin   = (c0 > c1) ? c1 : c0;
  assign cmax   = (c0 > c1) ? c0 : c1;
  assign rmin   = (r0 > r1) ? r1 : r0;
  assign rmax   = (r0 > r1) ? r0 : r1;
  assign rhi_m1 = rhi_r - CB'(1);
  assign chi_m1 = chi_r - CB'(1);
  assign i2     = {i_r[NB-2:0], 1'b0};
  assign j2     = {jc_r[NB-2:0], 1'b0};

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ok_nxt  = ok_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    jc_nxt  = jc_r;
    cur_nxt = cur_r;
    v_nxt   = v_r;
    tmp_nxt = tmp_r;
    tot_nxt = tot_r;
    cbl_nxt = cbl_r;
    cbh_nxt = cbh_r;
    rlo_nxt = rlo_r;
    rhi_nxt = rhi_r;
    clo_nxt = clo_r;
    chi_nxt = chi_r;
    if (cmd.clr_wr) clr_cnt_nxt = clr_cnt_r + AW'(1);
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_data_nxt = tot_r;
    if (cmd.load) begin
      ok_nxt  = (32'(col_a) < 32'(SIDE)) && (32'(row_a) < 32'(SIDE));
      i_nxt   = NB'(row_a) + NB'(TREE_H);
      j_nxt   = NB'(col_a) + NB'(TREE_H);
      v_nxt   = SUM_W'(value) & VMASK;
      tot_nxt = '0;
      cbl_nxt = cmin + CB'(TREE_H);
      cbh_nxt = cmax + CB'(TREE_H) + CB'(1);
      rlo_nxt = rmin + CB'(TREE_H);
      rhi_nxt = rmax + CB'(TREE_H) + CB'(1);
    end
    if (cmd.leaf_wr) jc_nxt = j_r;
    if (cmd.jc_shift) jc_nxt = jc_r >> 1;
    if (cmd.i_shift) begin
      i_nxt  = i_r >> 1;
      jc_nxt = j_r;
    end
    if (cmd.lat_a) tmp_nxt = rdata_r;
    if (cmd.row_lo_take) begin
      cur_nxt = rlo_r[NB-1:0];
      rlo_nxt = rlo_r + CB'(1);
      clo_nxt = cbl_r;
      chi_nxt = cbh_r;
    end
    if (cmd.row_hi_take) begin
      cur_nxt = rhi_m1[NB-1:0];
      rhi_nxt = rhi_m1;
      clo_nxt = cbl_r;
      chi_nxt = cbh_r;
    end
    if (cmd.row_shift) begin
      rlo_nxt = rlo_r >> 1;
      rhi_nxt = rhi_r >> 1;
    end
    if (cmd.col_lo_rd) clo_nxt = clo_r + CB'(1);
    if (cmd.col_hi_rd) chi_nxt = chi_m1;
    if (cmd.acc) tot_nxt = tot_r + rdata_r;
    if (cmd.col_shift) begin
      clo_nxt = clo_r >> 1;
      chi_nxt = chi_r >> 1;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
      wa = clr_cnt_r;
    end else if (cmd.leaf_wr) begin
      we = 1'b1;
      wa = {i_r, j_r};
      wd = v_r;
    end else if (cmd.sum_wr) begin
      we = 1'b1;
      wa = cmd.row_mode ? {i_r, j_r} : {i_r, jc_r};
      wd = tmp_r + rdata_r;
    end
    if (cmd.rd_a) ra = cmd.row_mode ? {i2, j_r} : {i_r, j2};
    else if (cmd.rd_b) ra = cmd.row_mode ? {i2 | NB'(1), j_r} : {i_r, j2 | NB'(1)};
    else if (cmd.col_lo_rd) ra = {cur_r, clo_r[NB-1:0]};
    else if (cmd.col_hi_rd) ra = {cur_r, chi_m1[NB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ok_r  <= ok_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    jc_r  <= jc_nxt;
    cur_r <= cur_nxt;
    v_r   <= v_nxt;
    tmp_r <= tmp_nxt;
    tot_r <= tot_nxt;
    cbl_r <= cbl_nxt;
    cbh_r <= cbh_nxt;
    rlo_r <= rlo_nxt;
    rhi_r <= rhi_nxt;
    clo_r <= clo_nxt;
    chi_r <= chi_nxt;
  end

  assign sts.clr_done = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.upd_ok   = ok_r;
  assign sts.jc_gt1   = (jc_r > NB'(1));
  assign sts.i_gt1    = (i_r > NB'(1));
  assign sts.rlo_lt   = (rlo_r < rhi_r);
  assign sts.rlo_odd  = rlo_r[0];
  assign sts.rhi_odd  = rhi_r[0];
  assign sts.clo_lt   = (clo_r < chi_r);
  assign sts.clo_odd  = clo_r[0];
  assign sts.chi_odd  = chi_r[0];
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_rect_sum = out_data_r;

endmodule
